>>> sv/status_led_pattern_controller_defines.svh
// Assertion macros used by the top-level RTL.
`ifndef STATUS_LED_PATTERN_CONTROLLER_DEFINES_SVH
`define STATUS_LED_PATTERN_CONTROLLER_DEFINES_SVH

// cons must hold in the cycle after ante
`define SLPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slpc: next-cycle check failed");

// cons must hold in the same cycle as ante
`define SLPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slpc: same-cycle check failed");

`endif

>>> sv/slpc_pkg.sv
`default_nettype none

package slpc_pkg;

   localparam int TIME_BITS   = 32;
   localparam int OWNER_BITS  = 8;
   localparam int PERIOD_BITS = 16;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [OWNER_BITS-1:0] OWNER_NONE = '1;
   localparam logic [3:0] STATUS_NONE = 4'd8;

   localparam logic [PERIOD_BITS-1:0] SLOW_PERIOD_RST = 16'd500;
   localparam logic [PERIOD_BITS-1:0] LONG_PERIOD_RST = 16'd1000;
   localparam logic [PERIOD_BITS-1:0] FAST_PERIOD_RST = 16'd100;

   // lamp vector bit positions
   localparam int COLOR_BLUE  = 0;
   localparam int COLOR_GREEN = 1;
   localparam int COLOR_RED   = 2;

   typedef enum logic {
      CMD_SET  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_GREEN     = 3'd0,
      ST_RED_SLOW  = 3'd1,
      ST_BLUE_SLOW = 3'd2,
      ST_BLUE_LONG = 3'd3,
      ST_CYAN      = 3'd4,
      ST_WHITE     = 3'd5,
      ST_CALIB     = 3'd6,
      ST_CLEAR     = 3'd7
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SLOW = 2'd0,
      CSR_LONG = 2'd1,
      CSR_FAST = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      BLINK_NONE,
      BLINK_SLOW,
      BLINK_LONG,
      BLINK_FAST
   } blink_type;

   typedef struct packed {
      logic              command;
      logic [2:0]        status_code;
      logic signed [7:0] owner_id;
      logic              release_lock;
      logic [31:0]       now_ms;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       led_blue;
      logic       led_green;
      logic       led_red;
      logic [3:0] current_status;
   } rsp_type;

   typedef struct packed {
      logic [2:0] lamps;
      blink_type  blue_blink;
      blink_type  red_blink;
   } pattern_type;

   function automatic pattern_type pattern_of(logic [2:0] code);
      pattern_type p;
      p = '{lamps: 3'b000, blue_blink: BLINK_NONE, red_blink: BLINK_NONE};
      case (code)
         ST_GREEN: p.lamps = 3'b010;
         ST_RED_SLOW: begin
            p.lamps     = 3'b100;
            p.red_blink = BLINK_SLOW;
         end
         ST_BLUE_SLOW: begin
            p.lamps      = 3'b011;
            p.blue_blink = BLINK_SLOW;
         end
         ST_BLUE_LONG: begin
            p.lamps      = 3'b011;
            p.blue_blink = BLINK_LONG;
         end
         ST_CYAN:  p.lamps = 3'b011;
         ST_WHITE: p.lamps = 3'b111;
         ST_CALIB: begin
            p.lamps     = 3'b110;
            p.red_blink = BLINK_FAST;
         end
         default: p.lamps = 3'b000;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

>>> sv/status_led_pattern_controller.sv
// Status lamp controller for a blue/green/red lamp. Set-status and tick items
// enter on the req_ channel and each yields exactly one result on rsp_, in order.
// An item is registered on entry, evaluated combinationally against the lock, pattern
// and blink state, and its result is registered: one item per cycle while rsp_stall
// stays low. One request and one result can be held while rsp_stall is high before
// req_stall rises. Blink periods are written through the csr_ port (0 slow, 1 long,
// 2 fast) by the user only while the block is idle; the block does not enforce it.
`default_nettype none

`include "status_led_pattern_controller_defines.svh"

module status_led_pattern_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire slpc_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output slpc_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [slpc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [slpc_pkg::PERIOD_BITS-1:0]    csr_wr_data
);

   logic              in_valid_ff, in_valid_in;
   slpc_pkg::req_type in_item_ff, in_item_in;
   logic              take;
   logic              fire;
   logic              out_space;
   slpc_pkg::rsp_type result;

   assign fire      = in_valid_ff && out_space;
   assign req_stall = in_valid_ff && !out_space;
   assign take      = req_valid && !req_stall;

   assign in_valid_in = take || (in_valid_ff && !fire);
   assign in_item_in  = take ? req_data : in_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   slpc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (in_item_ff),
      .result      (result)
   );

   slpc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .din       (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .space     (out_space)
   );

   `SLPC_ASSERT_NEXT(a_tick_accepted, clock, reset, fire && in_item_ff.command == slpc_pkg::CMD_TICK, rsp_valid && rsp_data.accepted)
   `SLPC_ASSERT_SAME(a_status_range, clock, reset, rsp_valid, rsp_data.current_status <= slpc_pkg::STATUS_NONE)

endmodule

`default_nettype wire

>>> sv/slpc_core.sv
`default_nettype none

module slpc_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [slpc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [slpc_pkg::PERIOD_BITS-1:0]    csr_wr_data,
   input  wire logic                                fire,
   input  wire slpc_pkg::req_type                   item,
   output slpc_pkg::rsp_type                        result
);

   logic [slpc_pkg::PERIOD_BITS-1:0] slow_period_ff, slow_period_in;
   logic [slpc_pkg::PERIOD_BITS-1:0] long_period_ff, long_period_in;
   logic [slpc_pkg::PERIOD_BITS-1:0] fast_period_ff, fast_period_in;

   logic [slpc_pkg::OWNER_BITS-1:0]  lock_owner_ff, lock_owner_in;
   logic [3:0]                       status_ff, status_in;
   logic [2:0]                       lamp_ff, lamp_in;
   logic [2:0]                       pin_ff, pin_in;
   logic [slpc_pkg::PERIOD_BITS-1:0] period_ff [3];
   logic [slpc_pkg::PERIOD_BITS-1:0] period_in [3];
   logic [slpc_pkg::TIME_BITS-1:0]   last_ff [3];
   logic [slpc_pkg::TIME_BITS-1:0]   last_in [3];

   logic [slpc_pkg::OWNER_BITS-1:0]  owner;
   logic [slpc_pkg::TIME_BITS-1:0]   now;
   logic [slpc_pkg::TIME_BITS-1:0]   elapsed [3];
   slpc_pkg::pattern_type            pat;
   logic                             accepted;

   function automatic logic [slpc_pkg::PERIOD_BITS-1:0] pick_period(
      slpc_pkg::blink_type sel,
      logic [slpc_pkg::PERIOD_BITS-1:0] slow_p,
      logic [slpc_pkg::PERIOD_BITS-1:0] long_p,
      logic [slpc_pkg::PERIOD_BITS-1:0] fast_p);
      logic [slpc_pkg::PERIOD_BITS-1:0] p;
      case (sel)
         slpc_pkg::BLINK_SLOW: p = slow_p;
         slpc_pkg::BLINK_LONG: p = long_p;
         slpc_pkg::BLINK_FAST: p = fast_p;
         default:              p = '0;
      endcase
      return p;
   endfunction

   // configuration writes
   always_comb begin
      slow_period_in = slow_period_ff;
      long_period_in = long_period_ff;
      fast_period_in = fast_period_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            slpc_pkg::CSR_SLOW: slow_period_in = csr_wr_data;
            slpc_pkg::CSR_LONG: long_period_in = csr_wr_data;
            slpc_pkg::CSR_FAST: fast_period_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   assign owner = slpc_pkg::OWNER_BITS'(item.owner_id);
   assign now   = slpc_pkg::TIME_BITS'(item.now_ms);
   assign pat   = slpc_pkg::pattern_of(item.status_code);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         elapsed[c] = now - last_ff[c];
      end
   end

   always_comb begin
      lock_owner_in = lock_owner_ff;
      status_in     = status_ff;
      lamp_in       = lamp_ff;
      pin_in        = pin_ff;
      period_in     = period_ff;
      last_in       = last_ff;
      accepted      = 1'b1;
      if (fire) begin
         if (item.command == slpc_pkg::CMD_SET) begin
            if (lock_owner_ff != slpc_pkg::OWNER_NONE && owner != lock_owner_ff) begin
               accepted = 1'b0;
            end else if ({1'b0, item.status_code} != status_ff) begin
               if (lock_owner_ff == slpc_pkg::OWNER_NONE && owner != slpc_pkg::OWNER_NONE) begin
                  lock_owner_in = owner;
               end
               lamp_in = pat.lamps;
               period_in[slpc_pkg::COLOR_BLUE] = pick_period(pat.blue_blink,
                  slow_period_ff, long_period_ff, fast_period_ff);
               period_in[slpc_pkg::COLOR_GREEN] = '0;
               period_in[slpc_pkg::COLOR_RED] = pick_period(pat.red_blink,
                  slow_period_ff, long_period_ff, fast_period_ff);
               // clear code leaves the pins until the next tick or non-clear set
               if (item.status_code != slpc_pkg::ST_CLEAR) begin
                  pin_in = pat.lamps;
               end
               status_in = {1'b0, item.status_code};
               if (item.release_lock) begin
                  lock_owner_in = slpc_pkg::OWNER_NONE;
               end
            end
         end else begin
            for (int c = 0; c < 3; c++) begin
               if (period_ff[c] != '0 &&
                   elapsed[c] > slpc_pkg::TIME_BITS'(period_ff[c])) begin
                  lamp_in[c] = ~lamp_ff[c];
                  last_in[c] = now;
               end
            end
            pin_in = lamp_in;
         end
      end
   end

   assign result.accepted       = accepted;
   assign result.led_blue       = pin_in[slpc_pkg::COLOR_BLUE];
   assign result.led_green      = pin_in[slpc_pkg::COLOR_GREEN];
   assign result.led_red        = pin_in[slpc_pkg::COLOR_RED];
   assign result.current_status = status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_period_ff <= slpc_pkg::SLOW_PERIOD_RST;
         long_period_ff <= slpc_pkg::LONG_PERIOD_RST;
         fast_period_ff <= slpc_pkg::FAST_PERIOD_RST;
         lock_owner_ff  <= slpc_pkg::OWNER_NONE;
         status_ff      <= slpc_pkg::STATUS_NONE;
         lamp_ff        <= '0;
         pin_ff         <= '0;
         for (int c = 0; c < 3; c++) begin
            period_ff[c] <= '0;
            last_ff[c]   <= '0;
         end
      end else begin
         slow_period_ff <= slow_period_in;
         long_period_ff <= long_period_in;
         fast_period_ff <= fast_period_in;
         lock_owner_ff  <= lock_owner_in;
         status_ff      <= status_in;
         lamp_ff        <= lamp_in;
         pin_ff         <= pin_in;
         period_ff      <= period_in;
         last_ff        <= last_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/slpc_out_reg.sv
`default_nettype none

module slpc_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire slpc_pkg::rsp_type din,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output slpc_pkg::rsp_type      rsp_data,
   output logic                   space
);

   logic              valid_ff, valid_in;
   slpc_pkg::rsp_type data_ff, data_in;

   // room when empty or when the held result transfers this cycle
   assign space    = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);
   assign data_in  = load ? din : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import slpc_pkg::*;

   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SECTION_REQS = 220;
   localparam int SECTIONS     = 6;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } lamp_row;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [PERIOD_BITS-1:0] csr_wr_data;

   status_led_pattern_controller uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // lamp model state
   logic [PERIOD_BITS-1:0] cfg_slow, cfg_long, cfg_fast;
   logic [OWNER_BITS-1:0]  lock_holder;
   logic [3:0]             shown_status;
   logic [2:0]             lamp_on;
   logic [2:0]             pin_on;
   logic [PERIOD_BITS-1:0] blink_ms [3];
   logic [TIME_BITS-1:0]   toggled_at [3];

   rsp_type lamp_expected [$];
   lamp_row plan [$];
   int mismatches;
   int quiet_cycles;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off_request;
   logic [31:0] tick_clock;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic compute_lamp_state(input req_type r, output rsp_type o);
      logic [OWNER_BITS-1:0] who;
      logic [TIME_BITS-1:0] gap;
      bit ok;
      ok = 1'b1;
      if (r.command == CMD_SET) begin
         who = r.owner_id;
         if (lock_holder != OWNER_NONE && who != lock_holder) begin
            ok = 1'b0;
         end else if ({1'b0, r.status_code} != shown_status) begin
            if (lock_holder == OWNER_NONE && who != OWNER_NONE)
               lock_holder = who;
            lamp_on = '0;
            for (int c = 0; c < 3; c++)
               blink_ms[c] = '0;
            case (status_type'(r.status_code))
               ST_GREEN: lamp_on[COLOR_GREEN] = 1'b1;
               ST_RED_SLOW: begin
                  lamp_on[COLOR_RED]  = 1'b1;
                  blink_ms[COLOR_RED] = cfg_slow;
               end
               ST_BLUE_SLOW: begin
                  lamp_on[COLOR_BLUE]  = 1'b1;
                  lamp_on[COLOR_GREEN] = 1'b1;
                  blink_ms[COLOR_BLUE] = cfg_slow;
               end
               ST_BLUE_LONG: begin
                  lamp_on[COLOR_BLUE]  = 1'b1;
                  lamp_on[COLOR_GREEN] = 1'b1;
                  blink_ms[COLOR_BLUE] = cfg_long;
               end
               ST_CYAN: begin
                  lamp_on[COLOR_BLUE]  = 1'b1;
                  lamp_on[COLOR_GREEN] = 1'b1;
               end
               ST_WHITE: lamp_on = '1;
               ST_CALIB: begin
                  lamp_on[COLOR_GREEN] = 1'b1;
                  lamp_on[COLOR_RED]   = 1'b1;
                  blink_ms[COLOR_RED]  = cfg_fast;
               end
               default: ;
            endcase
            // clear leaves the pins alone until the next tick or non-clear set
            if (status_type'(r.status_code) != ST_CLEAR)
               pin_on = lamp_on;
            shown_status = {1'b0, r.status_code};
            if (r.release_lock)
               lock_holder = OWNER_NONE;
         end
      end else begin
         for (int c = 0; c < 3; c++) begin
            gap = r.now_ms - toggled_at[c];
            if (blink_ms[c] != '0 && gap > TIME_BITS'(blink_ms[c])) begin
               lamp_on[c]    = ~lamp_on[c];
               toggled_at[c] = r.now_ms;
            end
         end
         pin_on = lamp_on;
      end
      o.accepted       = ok;
      o.led_blue       = pin_on[COLOR_BLUE];
      o.led_green      = pin_on[COLOR_GREEN];
      o.led_red        = pin_on[COLOR_RED];
      o.current_status = shown_status;
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic add_row(input cmd_type cmd, input status_type code,
                          input logic [7:0] owner, input bit rel,
                          input logic [31:0] now, input bit typed, input rsp_type want);
      lamp_row row;
      row.item.command      = cmd;
      row.item.status_code  = code;
      row.item.owner_id     = owner;
      row.item.release_lock = rel;
      row.item.now_ms       = now;
      row.typed             = typed;
      row.want              = want;
      plan.push_back(row);
   endtask

   // offer one item, idling first at the sender's rate; leaves valid high on return
   task automatic send_lamp_req(input req_type item, input bit typed, input rsp_type want);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = item;
      do
         @(posedge clock);
      while (req_stall);
      compute_lamp_state(item, pred);
      lamp_expected.push_back(typed ? want : pred);
   endtask

   task automatic random_req(output req_type r);
      logic [63:0] raw;
      int roll;
      int sub;
      int peak;
      roll = $urandom_range(99);
      raw  = {$urandom, $urandom};
      r    = raw[$bits(req_type)-1:0];
      peak = int'(cfg_slow);
      if (int'(cfg_long) > peak) peak = int'(cfg_long);
      if (int'(cfg_fast) > peak) peak = int'(cfg_fast);
      if (roll < 10) begin
         // pure noise
      end else if (roll < 50) begin
         r.command = CMD_TICK;
         sub = $urandom_range(99);
         if (sub < 5)
            tick_clock = $urandom;
         else if (sub < 8)
            tick_clock = 32'hFFFF_FFFF - $urandom_range(0, 300);
         else
            tick_clock = tick_clock + $urandom_range(0, 2 * peak + 3);
         r.now_ms = tick_clock;
      end else begin
         r.command     = CMD_SET;
         r.status_code = 3'($urandom_range(0, 7));
         sub = $urandom_range(99);
         if (sub < 35)
            r.owner_id = OWNER_NONE;
         else if (sub < 70)
            r.owner_id = lock_holder;
         else if (sub < 90)
            r.owner_id = 8'($urandom_range(0, 3));
         r.release_lock = ($urandom_range(99) < 40);
      end
   endtask

   task automatic wait_lamp_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (lamp_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_periods(input logic [15:0] slow, input logic [15:0] lng,
                              input logic [15:0] fast);
      wait_lamp_idle();
      csr_wr_en   = 1'b1;
      csr_index   = CSR_SLOW;
      csr_wr_data = slow;
      @(negedge clock);
      csr_index   = CSR_LONG;
      csr_wr_data = lng;
      @(negedge clock);
      csr_index   = CSR_FAST;
      csr_wr_data = fast;
      @(negedge clock);
      csr_wr_en = 1'b0;
      cfg_slow  = slow;
      cfg_long  = lng;
      cfg_fast  = fast;
   endtask

   // receiver: random stall, or a long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lamp_expected.size() == 0) begin
            note_mismatch("result with nothing expected", 32'(rsp_data), 32'd0);
         end else begin
            want = lamp_expected.pop_front();
            if (rsp_data.accepted !== want.accepted)
               note_mismatch("accepted", 32'(rsp_data.accepted), 32'(want.accepted));
            if (rsp_data.led_blue !== want.led_blue)
               note_mismatch("led_blue", 32'(rsp_data.led_blue), 32'(want.led_blue));
            if (rsp_data.led_green !== want.led_green)
               note_mismatch("led_green", 32'(rsp_data.led_green), 32'(want.led_green));
            if (rsp_data.led_red !== want.led_red)
               note_mismatch("led_red", 32'(rsp_data.led_red), 32'(want.led_red));
            if (rsp_data.current_status !== want.current_status)
               note_mismatch("current_status", 32'(rsp_data.current_status),
                             32'(want.current_status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      req_type item;
      logic [15:0] ps, pl, pf;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wr_data      = '0;
      hold_off_request = 1'b0;
      send_idle_pct    = 34;
      recv_idle_pct    = 63;
      mismatches       = 0;
      quiet_cycles     = 0;
      tick_clock       = '0;
      cfg_slow         = SLOW_PERIOD_RST;
      cfg_long         = LONG_PERIOD_RST;
      cfg_fast         = FAST_PERIOD_RST;
      lock_holder      = OWNER_NONE;
      shown_status     = STATUS_NONE;
      lamp_on          = '0;
      pin_on           = '0;
      for (int c = 0; c < 3; c++) begin
         blink_ms[c]   = '0;
         toggled_at[c] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // typed results are {accepted, blue, green, red, status}
      add_row(CMD_TICK, ST_GREEN,     8'h00, 0, 32'd0,   1, {1'b1, 3'b000, 4'd8});
      // clear with nothing shown yet: pins untouched
      add_row(CMD_SET,  ST_CLEAR,     8'hFF, 0, 32'd0,   1, {1'b1, 3'b000, 4'd7});
      add_row(CMD_SET,  ST_GREEN,     8'hFF, 0, 32'd0,   1, {1'b1, 3'b010, 4'd0});
      // repeat code does not claim the lock
      add_row(CMD_SET,  ST_GREEN,     8'h03, 0, 32'd0,   1, {1'b1, 3'b010, 4'd0});
      add_row(CMD_SET,  ST_WHITE,     8'h03, 0, 32'd0,   1, {1'b1, 3'b111, 4'd5});
      add_row(CMD_SET,  ST_CYAN,      8'h04, 0, 32'd0,   1, {1'b0, 3'b111, 4'd5});
      add_row(CMD_SET,  ST_CYAN,      8'hFF, 0, 32'd0,   1, {1'b0, 3'b111, 4'd5});
      add_row(CMD_SET,  ST_WHITE,     8'h04, 1, 32'd0,   1, {1'b0, 3'b111, 4'd5});
      // repeat by the holder ignores the release
      add_row(CMD_SET,  ST_WHITE,     8'h03, 1, 32'd0,   1, {1'b1, 3'b111, 4'd5});
      add_row(CMD_SET,  ST_CALIB,     8'h03, 1, 32'd0,   1, {1'b1, 3'b011, 4'd6});
      // blink needs elapsed strictly above the period
      add_row(CMD_TICK, ST_GREEN,     8'h00, 0, 32'd100, 1, {1'b1, 3'b011, 4'd6});
      add_row(CMD_TICK, ST_GREEN,     8'h00, 0, 32'd101, 1, {1'b1, 3'b010, 4'd6});
      add_row(CMD_SET,  ST_RED_SLOW,  8'h7F, 0, 32'd0,   1, {1'b1, 3'b001, 4'd1});
      add_row(CMD_TICK, ST_GREEN,     8'h00, 0, 32'd601, 1, {1'b1, 3'b001, 4'd1});
      add_row(CMD_TICK, ST_GREEN,     8'h00, 0, 32'd602, 1, {1'b1, 3'b000, 4'd1});
      add_row(CMD_SET,  ST_WHITE,     8'h7F, 0, 32'd0,   1, {1'b1, 3'b111, 4'd5});
      add_row(CMD_SET,  ST_CLEAR,     8'h7F, 0, 32'd0,   1, {1'b1, 3'b111, 4'd7});
      add_row(CMD_TICK, ST_GREEN,     8'h00, 0, 32'd603, 1, {1'b1, 3'b000, 4'd7});
      // owner -128 against holder 127
      add_row(CMD_SET,  ST_GREEN,     8'h80, 0, 32'd0,   1, {1'b0, 3'b000, 4'd7});
      add_row(CMD_SET,  ST_BLUE_SLOW, 8'h7F, 1, 32'd0,   1, {1'b1, 3'b110, 4'd2});
      // time wraps through zero
      add_row(CMD_TICK, ST_GREEN,     8'h00, 0, 32'hFFFF_FFFF, 0, 8'h00);
      add_row(CMD_TICK, ST_GREEN,     8'h00, 0, 32'd499, 0, 8'h00);
      add_row(CMD_TICK, ST_GREEN,     8'h00, 0, 32'd500, 0, 8'h00);
      add_row(CMD_SET,  ST_BLUE_LONG, 8'h80, 0, 32'd0,   0, 8'h00);
      add_row(CMD_SET,  ST_CYAN,      8'h80, 1, 32'hFFFF_FFFF, 0, 8'h00);
      // tick ignores code, owner and release
      add_row(CMD_TICK, ST_CLEAR,     8'h55, 1, 32'd1000, 0, 8'h00);
      add_row(CMD_SET,  ST_GREEN,     8'hFF, 1, 32'd0,   0, 8'h00);

      foreach (plan[i])
         send_lamp_req(plan[i].item, plan[i].typed, plan[i].want);
      tick_clock = 32'd1000;

      for (int s = 0; s < SECTIONS; s++) begin
         case (s)
            0: begin
               ps = '0; pl = '0; pf = '0;
            end
            1: begin
               ps = 16'($urandom_range(1, 40));
               pl = 16'($urandom_range(1, 40));
               pf = 16'($urandom_range(1, 40));
            end
            2: begin
               ps = '1; pl = '1; pf = '1;
            end
            3: begin
               ps = 16'($urandom_range(1, 300));
               pl = 16'($urandom_range(1, 300));
               pf = 16'($urandom_range(1, 300));
            end
            4: begin
               ps = 16'($urandom_range(1, 20));
               pl = 16'($urandom_range(1, 20));
               pf = 16'($urandom_range(1, 20));
            end
            default: begin
               ps = 16'($urandom_range(0, 65535));
               pl = 16'($urandom_range(0, 65535));
               pf = 16'($urandom_range(0, 65535));
            end
         endcase
         set_periods(ps, pl, pf);
         case (s / 2)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // back up the result side while the sender keeps offering
         if (s == 4)
            hold_off_request = 1'b1;
         repeat (SECTION_REQS) begin
            random_req(item);
            send_lamp_req(item, 1'b0, 8'h00);
         end
      end

      wait_lamp_idle();
      repeat (10) @(posedge clock);
      if (lamp_expected.size() != 0)
         note_mismatch("results never arrived", lamp_expected.size(), 32'd0);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
